FILE: design/saac_pkg.sv
`timescale 1ns / 1ps
package saac_pkg;

	// Operand widths of the shared serial units.
	localparam int MUL_A_W = 40;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W = 49;
	localparam int DIV_D_W = 32;
	localparam int DIV_Q_W = 39;

	// Configuration register indexes.
	localparam logic [2:0] CFG_LIN_MASS    = 3'd0;
	localparam logic [2:0] CFG_LIN_DAMPING = 3'd1;
	localparam logic [2:0] CFG_ROT_INERTIA = 3'd2;
	localparam logic [2:0] CFG_ROT_DAMPING = 3'd3;
	localparam logic [2:0] CFG_STEP_TIME   = 3'd4;
	localparam logic [2:0] CFG_VEL_LIMIT   = 3'd5;

	// Step bounds in Q8.24 (0.3 for translation, 0.2 for rotation).
	localparam logic [39:0] LIN_STEP_MAX = 40'd5033164;
	localparam logic [39:0] ROT_STEP_MAX = 40'd3355443;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic signed [31:0] torque_x;
		logic signed [31:0] torque_y;
		logic signed [31:0] torque_z;
	} wrench_t;

	typedef struct packed {
		logic signed [31:0] step_x;
		logic signed [31:0] step_y;
		logic signed [31:0] step_z;
		logic signed [31:0] turn_x;
		logic signed [31:0] turn_y;
		logic signed [31:0] turn_z;
		logic               overspeed_fault;
	} motion_t;

endpackage

FILE: design/saac_mul.sv
`timescale 1ns / 1ps
// Unsigned shift-add multiplier, one multiplier bit per cycle.
module saac_mul
	import saac_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic               done,
	output logic [MUL_P_W-1:0] p
);

	logic [MUL_A_W-1:0]         a_q;
	logic [MUL_A_W-1:0]         hi_q;
	logic [MUL_B_W-1:0]         lo_q;
	logic [$clog2(MUL_B_W)-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [MUL_A_W:0]           sum;

	// Partial sum of the upper half and the multiplicand when the low bit is set.
	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Product shift register.
	always_ff @(posedge clk) begin
		if (go) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[MUL_A_W:1];
			lo_q <= {sum[0], lo_q[MUL_B_W-1:1]};
		end
	end

	assign done = done_q;
	assign p    = {hi_q, lo_q};

endmodule

FILE: design/saac_div.sv
`timescale 1ns / 1ps
// Restoring divider: computes min(2^39-1, (num << 16) / den), one quotient bit per cycle.
// A zero divisor counts as one.
module saac_div
	import saac_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [DIV_N_W-1:0] num,
	input  logic [DIV_D_W-1:0] den,
	output logic               done,
	output logic [DIV_Q_W-1:0] q
);

	localparam int HI_SHIFT = DIV_N_W - 26;
	localparam int CNT_W    = $clog2(DIV_Q_W);

	logic [DIV_D_W-1:0] den_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_Q_W-1:0] sh_q;
	logic [DIV_Q_W-1:0] q_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DIV_D_W-1:0] den_eff;
	logic [DIV_D_W:0]   trial;
	logic               ge;

	assign den_eff = (den == '0) ? DIV_D_W'(1) : den;
	assign trial   = {rem_q, sh_q[DIV_Q_W-1]};
	assign ge      = trial >= {1'b0, den_q};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers. The quotient saturates when
	// the dividend reaches den << 39, which the load-time compare detects.
	always_ff @(posedge clk) begin
		if (go) begin
			den_q <= den_eff;
			ovf_q <= {6'b0, num} >= {den_eff, HI_SHIFT'(0)};
			rem_q <= DIV_D_W'(num[DIV_N_W-1:HI_SHIFT]);
			sh_q  <= {num[HI_SHIFT-1:0], 16'h0};
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_D_W'(trial - {1'b0, den_q}) : trial[DIV_D_W-1:0];
			sh_q  <= {sh_q[DIV_Q_W-2:0], 1'b0};
			q_q   <= {q_q[DIV_Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign q    = ovf_q ? '1 : q_q;

endmodule

FILE: design/six_axis_admittance_controller.sv
`timescale 1ns / 1ps
// Six-axis mass-damper admittance controller. Each wrench transfer yields one motion
// transfer: per axis a = (w - D*v)/M, v += a*dt clamped to the velocity limit, and the
// step v*dt + a*dt^2/2 from the old velocity. An axis with zero wrench gives step 0 and
// resets its velocity. If a step exceeds 0.3 (translation) or 0.2 (rotation) the result
// has all steps 0, overspeed_fault set, and no velocity changes. The axes are processed
// one after another through a shared bit-serial multiplier and a bit-serial divider: an
// axis with nonzero wrench runs a load step, the damping multiply, the divide and three
// more multiplies (dv, v*dt and dv*dt); a zero-wrench axis runs only the load step. After
// the last axis the block waits until the output register is empty or being taken, then
// writes the result there. A new wrench is taken while the previous result still waits
// on the output register. Configuration must be written only while the block is idle,
// through cfg_we/cfg_index/cfg_data; the block itself does not enforce this.
module six_axis_admittance_controller
	import saac_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        wrench_valid,
	output logic        wrench_ready,
	input  wrench_t     wrench,
	output logic        motion_valid,
	input  logic        motion_ready,
	output motion_t     motion
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_MDAMP = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_MDV   = 3'd4;
	localparam logic [2:0] ST_MV    = 3'd5;
	localparam logic [2:0] ST_MH    = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [31:0] lin_mass_q, lin_damping_q, rot_inertia_q, rot_damping_q;
	logic [23:0] step_time_q;
	logic [30:0] vel_limit_q;

	logic [2:0]         state_q;
	logic [2:0]         ax_q;
	wrench_t            wrench_q;
	logic signed [31:0] vel_q [6];
	logic signed [31:0] nv_q [6];
	logic signed [31:0] st_q [6];
	logic               fault_q;
	logic [48:0]        nummag_q;
	logic               num_neg_q;
	logic [38:0]        dvmag_q;
	logic [31:0]        s1_q;
	logic               out_valid_q;
	motion_t            out_q;

	logic               mul_go_q;
	logic [MUL_A_W-1:0] mul_a_q;
	logic [MUL_B_W-1:0] mul_b_q;
	logic               mul_done;
	logic [MUL_P_W-1:0] mul_p;
	logic               div_go_q;
	logic               div_done;
	logic [DIV_Q_W-1:0] div_q;

	logic signed [31:0] w_arr [6];
	logic signed [31:0] w_cur, v_cur;
	logic               is_lin, v_neg;
	logic [31:0]        vmag, mass_sel, damp_sel;
	logic [47:0]        dmag;
	logic [49:0]        num_d, num_abs;
	logic [40:0]        dv41, nv41, lim41;
	logic signed [31:0] nv_clamp;
	logic [37:0]        s2;
	logic [39:0]        step40, step_abs, step_max;

	assign w_arr[0] = wrench_q.force_x;
	assign w_arr[1] = wrench_q.force_y;
	assign w_arr[2] = wrench_q.force_z;
	assign w_arr[3] = wrench_q.torque_x;
	assign w_arr[4] = wrench_q.torque_y;
	assign w_arr[5] = wrench_q.torque_z;

	// Operands of the current axis.
	assign is_lin   = ax_q < 3'd3;
	assign w_cur    = w_arr[ax_q];
	assign v_cur    = vel_q[ax_q];
	assign v_neg    = v_cur[31];
	assign vmag     = v_neg ? 32'(-v_cur) : 32'(v_cur);
	assign mass_sel = is_lin ? lin_mass_q : rot_inertia_q;
	assign damp_sel = is_lin ? lin_damping_q : rot_damping_q;
	assign step_max = is_lin ? LIN_STEP_MAX : ROT_STEP_MAX;

	// Numerator w*256 - sign(v)*((|v|*D) >> 16).
	assign dmag    = mul_p[63:16];
	assign num_d   = {{10{w_cur[31]}}, w_cur, 8'h0} -
		(v_neg ? -{2'b0, dmag} : {2'b0, dmag});
	assign num_abs = num_d[49] ? -num_d : num_d;

	// New velocity v + dv, clamped to the limit.
	assign dv41  = num_neg_q ? -{2'b0, dvmag_q} : {2'b0, dvmag_q};
	assign nv41  = {{9{v_cur[31]}}, v_cur} + dv41;
	assign lim41 = {10'b0, vel_limit_q};
	always_comb begin
		priority if ($signed(nv41) > $signed(lim41)) begin
			nv_clamp = 32'(lim41);
		end else if ($signed(nv41) < -$signed(lim41)) begin
			nv_clamp = 32'(-lim41);
		end else begin
			nv_clamp = nv41[31:0];
		end
	end

	// Step sign(v)*s1 + sign(dv)*s2 and its magnitude for the overspeed check.
	assign s2       = mul_p[62:25];
	assign step40   = (v_neg ? -{8'b0, s1_q} : {8'b0, s1_q}) +
		(num_neg_q ? -{2'b0, s2} : {2'b0, s2});
	assign step_abs = step40[39] ? -step40 : step40;

	saac_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	saac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.num    (nummag_q),
		.den    (mass_sel),
		.done   (div_done),
		.q      (div_q)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_mass_q    <= 32'd458752;
			lin_damping_q <= 32'd1966080;
			rot_inertia_q <= 32'd6554;
			rot_damping_q <= 32'd983040;
			step_time_q   <= 24'd201327;
			vel_limit_q   <= 31'd16777216;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LIN_MASS:    lin_mass_q    <= cfg_data;
				CFG_LIN_DAMPING: lin_damping_q <= cfg_data;
				CFG_ROT_INERTIA: rot_inertia_q <= cfg_data;
				CFG_ROT_DAMPING: rot_damping_q <= cfg_data;
				CFG_STEP_TIME:   step_time_q   <= cfg_data[23:0];
				CFG_VEL_LIMIT:   vel_limit_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Axis sequencer and velocity state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ax_q        <= '0;
			fault_q     <= 1'b0;
			mul_go_q    <= 1'b0;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				vel_q[i] <= '0;
			end
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			if (motion_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (wrench_valid) begin
						ax_q    <= '0;
						fault_q <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (w_cur == '0) begin
						nv_q[ax_q] <= '0;
						st_q[ax_q] <= '0;
						state_q    <= (ax_q == 3'd5) ? ST_OUT : ST_LOAD;
						ax_q       <= (ax_q == 3'd5) ? ax_q : ax_q + 1'b1;
					end else begin
						mul_a_q  <= {8'b0, vmag};
						mul_b_q  <= damp_sel;
						mul_go_q <= 1'b1;
						state_q  <= ST_MDAMP;
					end
				end
				ST_MDAMP: begin
					if (mul_done) begin
						nummag_q  <= num_abs[48:0];
						num_neg_q <= num_d[49];
						div_go_q  <= 1'b1;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						mul_a_q  <= {1'b0, div_q};
						mul_b_q  <= {8'b0, step_time_q};
						mul_go_q <= 1'b1;
						state_q  <= ST_MDV;
					end
				end
				ST_MDV: begin
					if (mul_done) begin
						dvmag_q  <= mul_p[62:24];
						mul_a_q  <= {8'b0, vmag};
						mul_go_q <= 1'b1;
						state_q  <= ST_MV;
					end
				end
				ST_MV: begin
					if (mul_done) begin
						nv_q[ax_q] <= nv_clamp;
						s1_q       <= mul_p[55:24];
						mul_a_q    <= {1'b0, dvmag_q};
						mul_go_q   <= 1'b1;
						state_q    <= ST_MH;
					end
				end
				ST_MH: begin
					if (mul_done) begin
						st_q[ax_q] <= step40[31:0];
						if (step_abs > step_max) begin
							fault_q <= 1'b1;
						end
						state_q <= (ax_q == 3'd5) ? ST_OUT : ST_LOAD;
						ax_q    <= (ax_q == 3'd5) ? ax_q : ax_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || motion_ready) begin
						out_valid_q <= 1'b1;
						if (!fault_q) begin
							for (int i = 0; i < 6; i++) begin
								vel_q[i] <= nv_q[i];
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Input capture and result register.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && wrench_valid) begin
			wrench_q <= wrench;
		end
		if (state_q == ST_OUT && (!out_valid_q || motion_ready)) begin
			out_q.step_x          <= fault_q ? '0 : st_q[0];
			out_q.step_y          <= fault_q ? '0 : st_q[1];
			out_q.step_z          <= fault_q ? '0 : st_q[2];
			out_q.turn_x          <= fault_q ? '0 : st_q[3];
			out_q.turn_y          <= fault_q ? '0 : st_q[4];
			out_q.turn_z          <= fault_q ? '0 : st_q[5];
			out_q.overspeed_fault <= fault_q;
		end
	end

	assign wrench_ready = state_q == ST_IDLE;
	assign motion_valid = out_valid_q;
	assign motion       = out_q;

endmodule
